### hdl/lqrs_pkg.sv
`default_nettype none
package lqrs_pkg;

    localparam int WINDOW_MAX_DEF = 16;

    localparam int SNR_W     = 16;
    localparam int RATE_W    = 3;
    localparam int MRATE_W   = 8;
    localparam int CONF_W    = 9;
    localparam int FAIL_W    = 8;
    localparam int RISK_W    = 5;
    localparam int LEN_W     = 5;
    localparam int ALPHA_W   = 16;
    localparam int SLOW_A_W  = 13;
    localparam int SPREAD_W  = 32;
    localparam int TRUST_W   = 5;
    localparam int CTX_W     = 3;
    localparam int KIND_W    = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_SNR  = 2'd0,
        KIND_OK   = 2'd1,
        KIND_FAIL = 2'd2,
        KIND_REQ  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FALLBACK  = 3'd0,
        CFG_FAIL_TH   = 3'd1,
        CFG_RISK_TH   = 3'd2,
        CFG_CONF_TH   = 3'd3,
        CFG_ALPHA     = 3'd4,
        CFG_MIN_SNR   = 3'd5,
        CFG_MAX_SNR   = 3'd6,
        CFG_WIN_LEN   = 3'd7
    } t_cfg_idx;

    typedef enum logic [CTX_W-1:0] {
        CTX_EMERGENCY     = 3'd0,
        CTX_POOR          = 3'd1,
        CTX_MARGINAL      = 3'd2,
        CTX_GOOD_UNSTABLE = 3'd3,
        CTX_GOOD_STABLE   = 3'd4,
        CTX_EXCELLENT     = 3'd5
    } t_ctx;

    localparam logic [RATE_W-1:0]          FALLBACK_RST = 3'd2;
    localparam logic [FAIL_W-1:0]          FAIL_TH_RST  = 8'd4;
    localparam logic [RISK_W-1:0]          RISK_TH_RST  = 5'd14;
    localparam logic [CONF_W-1:0]          CONF_TH_RST  = 9'd179;
    localparam logic [ALPHA_W-1:0]         ALPHA_RST    = 16'd6554;
    localparam logic signed [SNR_W-1:0]    MIN_SNR_RST  = -16'sd1280;
    localparam logic signed [SNR_W-1:0]    MAX_SNR_RST  = 16'sd7680;
    localparam logic [LEN_W-1:0]           WIN_LEN_RST  = 5'd10;

    localparam logic signed [SNR_W-1:0]    SNR_5DB      = 16'sd1280;
    localparam logic signed [SNR_W-1:0]    SNR_10DB     = 16'sd2560;
    localparam logic signed [SNR_W-1:0]    SNR_15DB     = 16'sd3840;
    localparam logic signed [SNR_W-1:0]    SNR_20DB     = 16'sd5120;
    localparam logic [SPREAD_W-1:0]        SPREAD_RST   = 32'd256;
    localparam logic [SPREAD_W-1:0]        SPREAD_3DB2  = 32'd768;
    localparam logic [SPREAD_W-1:0]        SPREAD_5DB2  = 32'd1280;

    localparam logic [TRUST_W-1:0]         TRUST_MAX    = 5'd20;
    localparam logic [TRUST_W-1:0]         TRUST_MIN    = 5'd2;
    localparam logic [RISK_W-1:0]          RISK_MAX     = 5'd20;

    // reciprocal constants: x/10 for 16-bit x, x/10 for 20-bit x, x/5 for 23-bit x
    localparam logic [15:0] RECIP10_16 = 16'd52429;
    localparam int          RECIP10_16_SH = 19;
    localparam logic [19:0] RECIP10_20 = 20'd838861;
    localparam int          RECIP10_20_SH = 23;
    localparam logic [23:0] RECIP5_23  = 24'd13421773;
    localparam int          RECIP5_23_SH = 26;

    function automatic logic [RATE_W-1:0] safe_rate(input t_ctx c);
        logic [RATE_W-1:0] r;
        unique case (c)
            CTX_EMERGENCY:     r = 3'd0;
            CTX_POOR:          r = 3'd1;
            CTX_MARGINAL:      r = 3'd3;
            CTX_GOOD_UNSTABLE: r = 3'd5;
            CTX_GOOD_STABLE:   r = 3'd6;
            CTX_EXCELLENT:     r = 3'd7;
            default:           r = 3'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/lqrs_req_if.sv
`default_nettype none
interface lqrs_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] snr;
    logic [7:0]         model_rate;
    logic               model_valid;
    logic [8:0]         model_confidence;
    logic [2:0]         max_rate;

    modport source (
        output valid, kind, snr, model_rate, model_valid, model_confidence, max_rate,
        input  ready
    );
    modport sink (
        input  valid, kind, snr, model_rate, model_valid, model_confidence, max_rate,
        output ready
    );
endinterface
`default_nettype wire

### hdl/lqrs_res_if.sv
`default_nettype none
interface lqrs_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] rate_index;
    logic [2:0] context_res;
    logic       emergency;
    logic [4:0] risk;
    logic       model_used;

    modport source (
        output valid, rate_index, context_res, emergency, risk, model_used,
        input  ready
    );
    modport sink (
        input  valid, rate_index, context_res, emergency, risk, model_used,
        output ready
    );
endinterface
`default_nettype wire

### hdl/link_quality_rate_selector.sv
// Rate request: result is registered into the result register once that is free.
// SNR report: stored from the input register. Success/failure report: held through the
// four-step update (average products, averages, squared deviation, spread divide).
// Requests and SNR reports sustain one item per cycle while the result side takes them.
// Reset (synchronous, active low) restores config, link and control state to defaults.
`default_nettype none
module link_quality_rate_selector #(
    parameter int WINDOW_MAX = lqrs_pkg::WINDOW_MAX_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [lqrs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [lqrs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    lqrs_req_if.sink                        i_req,
    lqrs_res_if.source                      o_res
);
    import lqrs_pkg::*;

    localparam int CW    = $clog2(WINDOW_MAX + 1);
    localparam int NW    = (CW > LEN_W) ? CW : LEN_W;
    localparam int CMP_W = CW + 4;

    typedef enum logic [3:0] {
        PH_EMA = 4'b0001,
        PH_AVG = 4'b0010,
        PH_SQR = 4'b0100,
        PH_SPR = 4'b1000
    } t_phase;

    // configuration
    logic [RATE_W-1:0]       r_fallback;
    logic [FAIL_W-1:0]       r_fail_th;
    logic [RISK_W-1:0]       r_risk_th;
    logic [CONF_W-1:0]       r_conf_th;
    logic [ALPHA_W-1:0]      r_alpha;
    logic signed [SNR_W-1:0] r_min_snr;
    logic signed [SNR_W-1:0] r_max_snr;
    logic [LEN_W-1:0]        r_win_len;
    logic [SLOW_A_W-1:0]     r_slow_alpha;

    // link state
    logic signed [SNR_W-1:0] r_last;
    logic signed [SNR_W-1:0] r_fast;
    logic signed [SNR_W-1:0] r_slow;
    logic                    r_primed;
    logic [SPREAD_W-1:0]     r_spread;
    logic [WINDOW_MAX-1:0]   r_bits;
    logic [CW-1:0]           r_fill;
    logic [FAIL_W-1:0]       r_fail_run;
    logic [TRUST_W-1:0]      r_trust;
    logic [CW-1:0]           r_succ;
    logic [CW-1:0]           r_fill_eff;

    // input stage
    logic                    r_in_valid;
    t_kind                   r_in_kind;
    logic signed [SNR_W-1:0] r_in_snr;
    logic [MRATE_W-1:0]      r_in_mrate;
    logic                    r_in_mvalid;
    logic [CONF_W-1:0]       r_in_conf;
    logic [RATE_W-1:0]       r_in_max_rate;
    t_phase                  r_phase;

    // update datapath registers
    logic signed [33:0]      r_prod_fast;
    logic signed [33:0]      r_prod_slow;
    logic [12:0]             r_qh;
    logic [15:0]             r_ql;
    logic [3:0]              r_rl;
    logic [SPREAD_W-1:0]     r_sq;

    // result stage
    logic                    r_out_valid;
    logic [RATE_W-1:0]       r_out_rate;
    t_ctx                    r_out_ctx;
    logic                    r_out_emerg;
    logic [RISK_W-1:0]       r_out_risk;
    logic                    r_out_used;

    logic                    w_accept;
    logic                    w_done;
    logic                    w_is_upd;
    logic                    w_ok;

    // ---------------------------------------------------------------- window
    logic [NW-1:0]           w_len_x;
    logic [CW-1:0]           w_n;
    logic [CW-1:0]           w_fill_cut;
    logic [CW-1:0]           w_cnt;
    logic [CW:0]             w_fill_inc;
    logic [CW-1:0]           n_fill;

    always_comb begin
        w_len_x = NW'(r_win_len);
        if (w_len_x == '0) begin
            w_len_x = NW'(1);
        end
        if (w_len_x > NW'(WINDOW_MAX)) begin
            w_len_x = NW'(WINDOW_MAX);
        end
        w_n = CW'(w_len_x);
        w_fill_cut = (r_fill < w_n) ? r_fill : w_n;
        w_cnt = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (r_bits[i] && (i < int'(w_fill_cut))) begin
                w_cnt = w_cnt + CW'(1);
            end
        end
        w_fill_inc = (CW+1)'(r_fill) + (CW+1)'(1);
        n_fill = (w_fill_inc > (CW+1)'(w_n)) ? w_n : CW'(w_fill_inc);
    end

    // ---------------------------------------------------------------- update path
    logic signed [SNR_W-1:0] w_s;
    logic                    w_in_range;
    logic signed [16:0]      w_dfast;
    logic signed [16:0]      w_dslow;
    logic [31:0]             w_qh_prod;
    logic [31:0]             w_slow_prod;
    logic signed [17:0]      w_qfast;
    logic signed [17:0]      w_qslow;
    logic [15:0]             w_rh_full;
    logic [19:0]             w_x;
    logic [39:0]             w_ql_prod;
    logic [15:0]             w_ql;
    logic [19:0]             w_rl_full;
    logic signed [16:0]      w_d;
    logic signed [33:0]      w_d_sq;
    logic [SPREAD_W-1:0]     w_a;
    logic [47:0]             w_f_prod;
    logic [SPREAD_W-1:0]     w_spread_new;
    logic [28:0]             w_qv;

    always_comb begin
        w_s = (r_in_kind == KIND_OK && r_phase == PH_EMA) ? r_in_snr : r_last;
        w_in_range = (r_last >= r_min_snr) && (r_last <= r_max_snr);
        w_dfast = 17'(w_s) - 17'(r_fast);
        w_dslow = 17'(w_s) - 17'(r_slow);
        w_qh_prod = 32'(r_spread[31:16]) * 32'(RECIP10_16);
        w_slow_prod = 32'(r_alpha) * 32'(RECIP10_16);
        w_qfast = 18'((r_prod_fast + 34'sd32768) >>> 16);
        w_qslow = 18'((r_prod_slow + 34'sd32768) >>> 16);
        w_rh_full = r_spread[31:16] - 16'(r_qh) * 16'd10;
        w_x = {w_rh_full[3:0], r_spread[15:0]};
        w_ql_prod = 40'(w_x) * 40'(RECIP10_20);
        w_ql = w_ql_prod[RECIP10_20_SH +: 16];
        w_rl_full = w_x - 20'(w_ql) * 20'd10;
        w_d = 17'(r_last) - 17'(r_slow);
        w_d_sq = 34'(w_d) * 34'(w_d);
        w_a = r_sq + 32'd1280 + 32'(r_rl) * 32'd2304;
        w_f_prod = 48'(w_a[31:9]) * 48'(RECIP5_23);
        w_qv = {r_qh, r_ql};
        w_spread_new = 32'(w_qv) * 32'd9 + 32'(w_f_prod[RECIP5_23_SH +: 22]);
    end

    // ---------------------------------------------------------------- request path
    logic                    w_empty;
    logic                    w_lo_half;
    logic                    w_lo_08;
    logic                    w_hi_09;
    logic                    w_fail_hit;
    logic [CMP_W-1:0]        w_sx;
    logic [CMP_W-1:0]        w_fx;
    t_ctx                    w_ctx;
    logic [5:0]              w_risk_sum;
    logic [RISK_W-1:0]       w_risk;
    logic                    w_emerg;
    logic                    w_allowed;
    logic [RATE_W-1:0]       w_rule;
    logic [RATE_W-1:0]       w_fb;
    logic [MRATE_W-1:0]      w_mrate;
    logic [CONF_W-1:0]       w_mconf;
    logic [MRATE_W-1:0]      w_fin;
    logic                    w_used;
    logic [RATE_W-1:0]       w_rate;

    always_comb begin
        w_sx = CMP_W'(r_succ);
        w_fx = CMP_W'(r_fill_eff);
        w_empty = (r_fill_eff == '0);
        w_lo_half = !w_empty && (w_sx * CMP_W'(2) < w_fx);
        w_lo_08 = w_empty || (w_sx * CMP_W'(5) < w_fx * CMP_W'(4));
        w_hi_09 = !w_empty && (w_sx * CMP_W'(10) > w_fx * CMP_W'(9));
        w_fail_hit = (r_fail_run >= r_fail_th);

        priority if (r_last < SNR_5DB || w_lo_half || w_fail_hit) begin
            w_ctx = CTX_EMERGENCY;
        end else if (r_last < SNR_10DB || r_spread > SPREAD_5DB2) begin
            w_ctx = CTX_POOR;
        end else if (r_last < SNR_15DB || w_lo_08) begin
            w_ctx = CTX_MARGINAL;
        end else if (r_spread > SPREAD_3DB2) begin
            w_ctx = CTX_GOOD_UNSTABLE;
        end else if (r_last > SNR_20DB && w_hi_09) begin
            w_ctx = CTX_EXCELLENT;
        end else begin
            w_ctx = CTX_GOOD_STABLE;
        end

        w_risk_sum = (w_fail_hit ? 6'd10 : 6'd0)
                   + ((r_spread > SPREAD_5DB2) ? 6'd5 : 6'd0)
                   + ((r_last < SNR_5DB) ? 6'd5 : 6'd0)
                   + 6'(TRUST_MAX - r_trust);
        w_risk = (w_risk_sum > 6'(RISK_MAX)) ? RISK_MAX : w_risk_sum[RISK_W-1:0];

        w_emerg = (w_ctx == CTX_EMERGENCY) || w_fail_hit || (w_risk > r_risk_th);
        w_allowed = !w_emerg && (w_risk < r_risk_th);
        w_rule = safe_rate(w_ctx);
        w_fb = (r_fallback < r_in_max_rate) ? r_fallback : r_in_max_rate;

        w_mrate = MRATE_W'(r_fallback);
        w_mconf = '0;
        if (w_allowed) begin
            if (r_in_mvalid) begin
                w_mrate = (r_in_mrate <= MRATE_W'(r_in_max_rate)) ? r_in_mrate
                                                                    : MRATE_W'(w_fb);
                w_mconf = r_in_conf;
            end else begin
                w_mrate = MRATE_W'(w_fb);
            end
        end

        w_used = 1'b0;
        priority if (w_allowed && w_mconf > r_conf_th) begin
            w_fin = w_mrate;
            w_used = 1'b1;
        end else if (w_emerg) begin
            w_fin = MRATE_W'(w_rule);
        end else begin
            w_fin = (MRATE_W'(w_rule) < w_mrate) ? MRATE_W'(w_rule) : w_mrate;
        end
        w_rate = (w_fin > MRATE_W'(r_in_max_rate)) ? r_in_max_rate : w_fin[RATE_W-1:0];
    end

    // ---------------------------------------------------------------- handshake
    always_comb begin
        w_is_upd = (r_in_kind == KIND_OK) || (r_in_kind == KIND_FAIL);
        w_ok = (r_in_kind == KIND_OK);
        unique case (r_in_kind)
            KIND_SNR:  w_done = 1'b1;
            KIND_OK:   w_done = (r_phase == PH_SPR);
            KIND_FAIL: w_done = (r_phase == PH_SPR);
            KIND_REQ:  w_done = !r_out_valid || o_res.ready;
            default:   w_done = 1'b1;
        endcase
    end

    assign i_req.ready = !r_in_valid || w_done;
    assign w_accept    = i_req.valid && i_req.ready;

    assign o_res.valid       = r_out_valid;
    assign o_res.rate_index  = r_out_rate;
    assign o_res.context_res = r_out_ctx;
    assign o_res.emergency   = r_out_emerg;
    assign o_res.risk        = r_out_risk;
    assign o_res.model_used  = r_out_used;

    // ---------------------------------------------------------------- control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback   <= FALLBACK_RST;
            r_fail_th    <= FAIL_TH_RST;
            r_risk_th    <= RISK_TH_RST;
            r_conf_th    <= CONF_TH_RST;
            r_alpha      <= ALPHA_RST;
            r_min_snr    <= MIN_SNR_RST;
            r_max_snr    <= MAX_SNR_RST;
            r_win_len    <= WIN_LEN_RST;
            r_last       <= SNR_15DB;
            r_fast       <= SNR_15DB;
            r_slow       <= SNR_15DB;
            r_primed     <= 1'b0;
            r_spread     <= SPREAD_RST;
            r_bits       <= '0;
            r_fill       <= '0;
            r_fail_run   <= '0;
            r_trust      <= TRUST_MAX;
            r_succ       <= '0;
            r_fill_eff   <= '0;
            r_in_valid   <= 1'b0;
            r_phase      <= PH_EMA;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_FALLBACK: r_fallback <= i_cfg_data[RATE_W-1:0];
                    CFG_FAIL_TH:  r_fail_th  <= i_cfg_data[FAIL_W-1:0];
                    CFG_RISK_TH:  r_risk_th  <= i_cfg_data[RISK_W-1:0];
                    CFG_CONF_TH:  r_conf_th  <= i_cfg_data[CONF_W-1:0];
                    CFG_ALPHA:    r_alpha    <= i_cfg_data[ALPHA_W-1:0];
                    CFG_MIN_SNR:  r_min_snr  <= $signed(i_cfg_data[SNR_W-1:0]);
                    CFG_MAX_SNR:  r_max_snr  <= $signed(i_cfg_data[SNR_W-1:0]);
                    CFG_WIN_LEN:  r_win_len  <= i_cfg_data[LEN_W-1:0];
                    default:      r_fallback <= r_fallback;
                endcase
            end

            r_succ     <= w_cnt;
            r_fill_eff <= w_fill_cut;

            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (r_in_valid && w_done) begin
                r_in_valid <= 1'b0;
            end

            if (r_in_valid && w_is_upd) begin
                unique case (r_phase)
                    PH_EMA:  r_phase <= PH_AVG;
                    PH_AVG:  r_phase <= PH_SQR;
                    PH_SQR:  r_phase <= PH_SPR;
                    PH_SPR:  r_phase <= PH_EMA;
                    default: r_phase <= PH_EMA;
                endcase
            end else begin
                r_phase <= PH_EMA;
            end

            if (r_in_valid && r_in_kind == KIND_SNR) begin
                r_last <= r_in_snr;
            end

            if (r_in_valid && w_is_upd && r_phase == PH_EMA) begin
                if (w_ok) begin
                    r_last     <= r_in_snr;
                    r_fail_run <= '0;
                    r_trust    <= (r_trust < TRUST_MAX) ? r_trust + TRUST_W'(1) : TRUST_MAX;
                end else begin
                    if (r_fail_run != '1) begin
                        r_fail_run <= r_fail_run + FAIL_W'(1);
                    end
                    r_trust <= (r_trust < TRUST_W'(4)) ? TRUST_MIN : r_trust - TRUST_W'(2);
                end
                r_bits <= WINDOW_MAX'({r_bits, w_ok});
                r_fill <= n_fill;
            end

            if (r_in_valid && w_is_upd && r_phase == PH_AVG && w_in_range) begin
                r_primed <= 1'b1;
                if (!r_primed) begin
                    r_fast <= r_last;
                    r_slow <= r_last;
                end else begin
                    r_fast <= r_fast + w_qfast[15:0];
                    r_slow <= r_slow + w_qslow[15:0];
                end
            end

            if (r_in_valid && w_is_upd && r_phase == PH_SPR) begin
                r_spread <= w_spread_new;
            end

            if (r_in_valid && r_in_kind == KIND_REQ && w_done) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge i_clk) begin
        r_slow_alpha <= w_slow_prod[RECIP10_16_SH +: SLOW_A_W];
        if (w_accept) begin
            r_in_kind     <= t_kind'(i_req.kind);
            r_in_snr      <= i_req.snr;
            r_in_mrate    <= i_req.model_rate;
            r_in_mvalid   <= i_req.model_valid;
            r_in_conf     <= i_req.model_confidence;
            r_in_max_rate <= i_req.max_rate;
        end
        if (r_phase == PH_EMA) begin
            r_prod_fast <= 34'($signed({1'b0, r_alpha})) * 34'(w_dfast);
            r_prod_slow <= 34'($signed({1'b0, r_slow_alpha})) * 34'(w_dslow);
            r_qh        <= w_qh_prod[RECIP10_16_SH +: 13];
        end
        if (r_phase == PH_AVG) begin
            r_ql <= w_ql;
            r_rl <= w_rl_full[3:0];
        end
        if (r_phase == PH_SQR) begin
            r_sq <= w_d_sq[SPREAD_W-1:0];
        end
        if (r_in_valid && r_in_kind == KIND_REQ && w_done) begin
            r_out_rate  <= w_rate;
            r_out_ctx   <= w_ctx;
            r_out_emerg <= w_emerg;
            r_out_risk  <= w_risk;
            r_out_used  <= w_used;
        end
    end

    // ---------------------------------------------------------------- assertions
    a_trust_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_trust >= TRUST_MIN) && (r_trust <= TRUST_MAX))
        else $error("trust score out of range");

    a_phase_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_EMA) |-> (r_in_valid && w_is_upd))
        else $error("update phase advanced without an update item");

    a_ctx_emerg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ctx == CTX_EMERGENCY) |-> r_out_emerg)
        else $error("emergency context without emergency flag");

    a_used_calm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_used) |-> (!r_out_emerg && r_out_risk < r_risk_th))
        else $error("model rate taken under emergency or high risk");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_eff <= CW'(WINDOW_MAX)) && (r_succ <= r_fill_eff))
        else $error("window count exceeds fill");

endmodule
`default_nettype wire
